// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/cpu8_pkg.sv =====
// Types and constants for the 8-bit opcode execute block
package cpu8_pkg;
    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] FLAG_Z = 8'h80;
    localparam logic [7:0] FLAG_H = 8'h20;
    localparam logic [7:0] FLAG_C = 8'h10;
    localparam logic [7:0] FLAG_C_CLR = 8'hEF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  opcode;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  reg_a;
        logic [7:0]  reg_b;
        logic [7:0]  reg_c;
        logic [7:0]  reg_d;
        logic [7:0]  reg_e;
        logic [7:0]  reg_h;
        logic [7:0]  reg_l;
        logic [7:0]  flag_bits;
        logic [15:0] prog_counter;
        logic [15:0] stack_ptr;
        logic [1:0]  m_cycles;
        logic [7:0]  read_byte;
    } out_word_t;

    // instruction classes decided by the front end
    typedef enum logic [3:0] {
        CL_NONE, CL_NOP, CL_LD_RR, CL_LD_R_HL, CL_INCDEC8, CL_INCDEC_HL,
        CL_LD_R_IMM, CL_LD_HL_IMM, CL_LD16_IMM, CL_INCDEC16, CL_ADD_HL,
        CL_ST_A, CL_LD_A, CL_ALU_A, CL_ST_SP, CL_JR
    } op_class_t;

    typedef struct packed {
        logic [1:0]  cmd;
        op_class_t   cls;
        logic [7:0]  opcode;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
    } dec_word_t;

    // register-file slot for a 3-bit register code; A is slot 0
    function automatic logic [2:0] slot_of(input logic [2:0] code);
        case (code)
            3'd0: slot_of = 3'd1;
            3'd1: slot_of = 3'd2;
            3'd2: slot_of = 3'd3;
            3'd3: slot_of = 3'd4;
            3'd4: slot_of = 3'd5;
            3'd5: slot_of = 3'd6;
            default: slot_of = 3'd0;
        endcase
    endfunction
endpackage

// ===== rtl/core/cpu8_ram.sv =====
// Generic single-port RAM with registered read
module cpu8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/cpu8_front.sv =====
// Front end: accepts words, classifies opcodes, holds a two-entry queue
module cpu8_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cpu8_pkg::in_word_t  s_data,
    output logic                q_valid,
    input  logic                q_ready,
    output cpu8_pkg::dec_word_t q_data
);
    import cpu8_pkg::*;

    dec_word_t  q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    op_class_t  cls;
    logic [7:0] op;
    logic       push, pop;

    assign op = s_data.opcode;

    always_comb begin
        cls = CL_NONE;
        if (op >= 8'h60) begin
            cls = CL_NONE;
        end else if (op >= 8'h40) begin
            cls = (op[2:0] == 3'd6) ? CL_LD_R_HL : CL_LD_RR;
        end else if (op[2:1] == 2'b10) begin
            cls = (op[5:3] == 3'd6) ? CL_INCDEC_HL : CL_INCDEC8;
        end else if (op[2:0] == 3'd6) begin
            cls = (op[5:3] == 3'd6) ? CL_LD_HL_IMM : CL_LD_R_IMM;
        end else if (op[3:0] == 4'h1) begin
            cls = CL_LD16_IMM;
        end else if (op[3:0] == 4'h3 || op[3:0] == 4'hB) begin
            cls = CL_INCDEC16;
        end else if (op[3:0] == 4'h9) begin
            cls = CL_ADD_HL;
        end else begin
            case (op)
                8'h00: cls = CL_NOP;
                8'h02, 8'h12, 8'h22, 8'h32: cls = CL_ST_A;
                8'h0A, 8'h1A, 8'h2A, 8'h3A: cls = CL_LD_A;
                8'h07, 8'h0F, 8'h17, 8'h1F, 8'h27, 8'h2F, 8'h37, 8'h3F: cls = CL_ALU_A;
                8'h08: cls = CL_ST_SP;
                8'h18, 8'h20, 8'h28, 8'h30, 8'h38: cls = CL_JR;
                default: cls = CL_NONE;
            endcase
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= '{cmd: s_data.cmd, cls: cls, opcode: op,
                               mem_addr: s_data.mem_addr, mem_data: s_data.mem_data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/core/cpu8_back.sv =====
// Back end: sequences one queued word (instruction, memory write or memory read) against registers and memory
module cpu8_back #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  cpu8_pkg::dec_word_t  q_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cpu8_pkg::out_word_t  m_data,
    output logic                 busy
);
    import cpu8_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD0  = 6'b000010,
        ST_RD1  = 6'b000100,
        ST_RD2  = 6'b001000,
        ST_WR1  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    dec_word_t   cur_reg, cur_next;
    logic [7:0]  gp_reg [7];
    logic [7:0]  gp_next [7];
    logic [7:0]  f_reg, f_next;
    logic [15:0] pc_reg, pc_next, sp_reg, sp_next;
    logic [7:0]  lo_reg, lo_next;
    logic        ov_reg, ov_next;
    out_word_t   out_reg, out_next;
    logic        ovalid_reg, ovalid_next;

    logic                     we;
    logic [MEM_ADDR_BITS-1:0] maddr;
    logic [7:0]               wdata, rdata;

    cpu8_ram #(.WIDTH(8), .DEPTH(2 ** MEM_ADDR_BITS)) u_ram (
        .aclk(aclk), .we(we), .addr(maddr), .wdata(wdata), .rdata(rdata)
    );

    logic [15:0] hl, rr_p, rr_sum, jr_tgt;
    logic [16:0] add_hl;
    logic [1:0]  p;
    logic [2:0]  rs, rd;
    logic [7:0]  a, dv, inc_v, ad_v;
    logic        take, go;
    logic [15:0] addr16;

    assign p  = cur_reg.opcode[5:4];
    assign rd = slot_of(cur_reg.opcode[5:3]);
    assign rs = slot_of(cur_reg.opcode[2:0]);
    assign hl = {gp_reg[5], gp_reg[6]};
    assign a  = gp_reg[0];
    assign dv = cur_reg.opcode[0] ? 8'hFF : 8'h01;

    always_comb begin
        case (p)
            2'd0: rr_p = {gp_reg[1], gp_reg[2]};
            2'd1: rr_p = {gp_reg[3], gp_reg[4]};
            2'd2: rr_p = hl;
            default: rr_p = sp_reg;
        endcase
    end

    assign rr_sum = rr_p + (cur_reg.opcode[3] ? 16'hFFFF : 16'h0001);
    assign add_hl = {1'b0, hl} + {1'b0, rr_p};
    assign jr_tgt = pc_reg + {{8{rdata[7]}}, rdata};

    always_comb begin
        case (cur_reg.opcode[5:3])
            3'd4: take = !f_reg[7];
            3'd5: take = f_reg[7];
            3'd6: take = !f_reg[4];
            3'd7: take = f_reg[4];
            default: take = 1'b1;
        endcase
    end

    // go: the back end is free to start the next queued word
    assign go = (state_reg == ST_IDLE) && (!ovalid_reg || m_ready);
    assign q_ready = go;
    assign busy = (state_reg != ST_IDLE) || ovalid_reg;

    always_comb begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        gp_next     = gp_reg;
        f_next      = f_reg;
        pc_next     = pc_reg;
        sp_next     = sp_reg;
        lo_next     = lo_reg;
        ov_next     = ov_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg && !m_ready;
        we          = 1'b0;
        addr16      = pc_reg;
        wdata       = a;
        inc_v       = 8'h00;
        ad_v        = 8'h00;
        case (state_reg)
            ST_IDLE: begin
                if (go && q_valid) begin
                    cur_next   = q_data;
                    state_next = ST_RD0;
                end
            end
            ST_RD0: begin
                // issue first access and do the work that needs no memory read
                state_next = ST_DONE;
                ov_next    = 1'b0;
                if (cur_reg.cmd == CMD_WRITE) begin
                    we = 1'b1; addr16 = cur_reg.mem_addr; wdata = cur_reg.mem_data;
                end else if (cur_reg.cmd == CMD_READ) begin
                    addr16 = cur_reg.mem_addr; state_next = ST_RD1;
                end else if (cur_reg.cmd == CMD_EXEC) begin
                    case (cur_reg.cls)
                        CL_LD_RR: gp_next[rd] = gp_reg[rs];
                        CL_LD_R_HL, CL_INCDEC_HL: begin
                            addr16 = hl; state_next = ST_RD1;
                        end
                        CL_LD_A: begin
                            addr16 = (p == 2'd0 || p == 2'd1) ? rr_p : hl;
                            state_next = ST_RD1;
                        end
                        CL_INCDEC8: begin
                            inc_v = gp_reg[rd] + dv;
                            gp_next[rd] = inc_v;
                            f_next = (inc_v == 8'h00) ? FLAG_Z : 8'h00;
                        end
                        CL_LD_R_IMM, CL_LD_HL_IMM, CL_LD16_IMM, CL_ST_SP, CL_JR: begin
                            addr16 = pc_reg; pc_next = pc_reg + 16'd1; state_next = ST_RD1;
                        end
                        CL_INCDEC16: begin
                            if (p == 2'd3) sp_next = rr_sum;
                            else begin
                                gp_next[{p, 1'b0} + 3'd1] = rr_sum[15:8];
                                gp_next[{p, 1'b0} + 3'd2] = rr_sum[7:0];
                            end
                        end
                        CL_ADD_HL: begin
                            f_next = add_hl[16] ? (f_reg | FLAG_C) : (f_reg & FLAG_C_CLR);
                            gp_next[5] = add_hl[15:8];
                            gp_next[6] = add_hl[7:0];
                        end
                        CL_ST_A: begin
                            we = 1'b1;
                            addr16 = (p == 2'd0 || p == 2'd1) ? rr_p : hl;
                            if (p == 2'd2 || p == 2'd3) begin
                                {gp_next[5], gp_next[6]} =
                                    hl + ((p == 2'd3) ? 16'hFFFF : 16'h0001);
                            end
                        end
                        CL_ALU_A: begin
                            case (cur_reg.opcode)
                                8'h07: begin gp_next[0] = {a[6:0], a[7]};
                                    f_next = (f_reg & FLAG_C_CLR) | (a[7] ? FLAG_C : 8'h00); end
                                8'h0F: begin gp_next[0] = {a[0], a[7:1]};
                                    f_next = (f_reg & FLAG_C_CLR) | (a[0] ? FLAG_C : 8'h00); end
                                8'h17: begin gp_next[0] = {a[6:0], f_reg[4]};
                                    f_next = (f_reg & FLAG_C_CLR) | (a[7] ? FLAG_C : 8'h00); end
                                8'h1F: begin gp_next[0] = {f_reg[4], a[7:1]};
                                    f_next = (f_reg & FLAG_C_CLR) | (a[0] ? FLAG_C : 8'h00); end
                                8'h27: begin
                                    ad_v = a;
                                    if (f_reg[5] || a[3:0] > 4'd9) ad_v = ad_v + 8'h06;
                                    f_next = f_reg & FLAG_C_CLR;
                                    if (f_reg[5] || a > 8'h99) begin
                                        ad_v = ad_v + 8'h60; f_next = f_next | FLAG_C;
                                    end
                                    gp_next[0] = ad_v;
                                end
                                8'h2F: begin gp_next[0] = ~a;
                                    f_next = (a == 8'hFF) ? FLAG_Z : 8'h00; end
                                8'h37: f_next = f_reg | FLAG_C;
                                default: f_next = f_reg & FLAG_C_CLR;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD1: begin
                // first read byte is valid
                state_next = ST_DONE;
                if (cur_reg.cmd == CMD_READ) begin
                    lo_next = rdata;
                end else begin
                    case (cur_reg.cls)
                        CL_LD_R_HL: gp_next[rd] = rdata;
                        CL_LD_A: begin
                            gp_next[0] = rdata;
                            if (p == 2'd2 || p == 2'd3)
                                {gp_next[5], gp_next[6]} =
                                    hl + ((p == 2'd3) ? 16'hFFFF : 16'h0001);
                        end
                        CL_INCDEC_HL: begin
                            inc_v = rdata + dv;
                            we = 1'b1; addr16 = hl; wdata = inc_v;
                            f_next = (inc_v == 8'h00) ? FLAG_Z : 8'h00;
                        end
                        CL_LD_R_IMM: gp_next[rd] = rdata;
                        CL_LD_HL_IMM: begin we = 1'b1; addr16 = hl; wdata = rdata; end
                        CL_JR: if (take) begin pc_next = jr_tgt; ov_next = 1'b1; end
                        default: begin
                            // second immediate byte
                            lo_next = rdata; addr16 = pc_reg;
                            pc_next = pc_reg + 16'd1; state_next = ST_RD2;
                        end
                    endcase
                end
            end
            ST_RD2: begin
                state_next = ST_DONE;
                if (cur_reg.cls == CL_LD16_IMM) begin
                    if (p == 2'd3) sp_next = {rdata, lo_reg};
                    else begin
                        gp_next[{p, 1'b0} + 3'd1] = rdata;
                        gp_next[{p, 1'b0} + 3'd2] = lo_reg;
                    end
                end else begin
                    we = 1'b1; addr16 = {rdata, lo_reg}; wdata = sp_reg[7:0];
                    lo_next = rdata; state_next = ST_WR1;
                    cur_next.mem_addr = {rdata, lo_reg} + 16'd1;
                end
            end
            ST_WR1: begin
                we = 1'b1; addr16 = cur_reg.mem_addr; wdata = sp_reg[15:8];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // output register is free here: go required it at start
                out_next.reg_a = gp_reg[0];
                out_next.reg_b = gp_reg[1];
                out_next.reg_c = gp_reg[2];
                out_next.reg_d = gp_reg[3];
                out_next.reg_e = gp_reg[4];
                out_next.reg_h = gp_reg[5];
                out_next.reg_l = gp_reg[6];
                out_next.flag_bits = f_reg;
                out_next.prog_counter = pc_reg;
                out_next.stack_ptr = sp_reg;
                out_next.read_byte = (cur_reg.cmd == CMD_READ) ? lo_reg : 8'h00;
                out_next.m_cycles = 2'd0;
                if (cur_reg.cmd == CMD_EXEC) begin
                    case (cur_reg.cls)
                        CL_NONE: out_next.m_cycles = 2'd0;
                        CL_NOP, CL_LD_RR, CL_INCDEC8, CL_INCDEC16, CL_ALU_A:
                            out_next.m_cycles = 2'd1;
                        CL_INCDEC_HL, CL_LD_HL_IMM, CL_LD16_IMM, CL_ADD_HL:
                            out_next.m_cycles = 2'd3;
                        CL_JR: out_next.m_cycles = ov_reg ? 2'd3 : 2'd2;
                        default: out_next.m_cycles = 2'd2;
                    endcase
                end
                ovalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        maddr = addr16[MEM_ADDR_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 7; i++) gp_reg[i] <= 8'h00;
            f_reg  <= 8'h00;
            pc_reg <= 16'h0000;
            sp_reg <= 16'h0000;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            gp_reg     <= gp_next;
            f_reg      <= f_next;
            pc_reg     <= pc_next;
            sp_reg     <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        lo_reg  <= lo_next;
        ov_reg  <= ov_next;
        out_reg <= out_next;
    end

    assign m_valid = ovalid_reg;
    assign m_data  = out_reg;
endmodule

// ===== rtl/core/cpu8_opcode_execute.sv =====
// Top level of the 8-bit opcode execute block
// Executes one word at a time: it is picked from the two-entry queue, then goes
// through up to four single-port memory accesses (immediates, reads, writes; each
// read is registered), and then the result register is loaded. While the queue
// is not full, the front end keeps accepting words while the back end works and
// while a result waits to be taken. Memory is not cleared after reset.
module cpu8_opcode_execute #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cpu8_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cpu8_pkg::out_word_t m_data
);
    import cpu8_pkg::*;
    `include "assert_macros.svh"

    logic      q_valid, q_ready, busy;
    dec_word_t q_data;

    cpu8_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    cpu8_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data), .busy(busy)
    );

    `ASSERT_IMPL(a_busy_out, aclk, aresetn, m_valid, busy, "result shown while back end idle")
    `ASSERT_NEXT(a_hold_out, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `ASSERT_IMPL(a_cyc_mem, aclk, aresetn, m_valid && m_data.read_byte != 8'h00, m_data.m_cycles == 2'd0, "read byte with nonzero cycles")
endmodule
